@@ sv/frsp_pkg.sv @@
// Package for the FASTA record stream parser.
// Holds operation, result kind and register index codes, character constants and
// the result record type. Has no dependencies.
package frsp_pkg;

  typedef enum logic [1:0] {
    OP_DATA = 2'd0,
    OP_END  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_HDR_CHAR  = 3'd0,
    KIND_HDR_END   = 3'd1,
    KIND_SEQ_CHAR  = 3'd2,
    KIND_REC_END   = 3'd3,
    KIND_COUNT     = 3'd4,
    KIND_NOT_FASTA = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CFG_MASK_LOW   = 3'd0,
    CFG_MASK_UPPER = 3'd1,
    CFG_MASK_HIGH  = 3'd2,
    CFG_MASK_TOP   = 3'd3,
    CFG_ALLOW_GAPS = 3'd4,
    CFG_NUC_MODE   = 3'd5,
    CFG_TRUNC_HDR  = 3'd6,
    CFG_MAX_LEN    = 3'd7
  } cfg_e;

  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  localparam logic [63:0] MASK_UPPER_RESET = 64'h07FF_FFFE_07FF_FFFE;
  localparam logic [23:0] MAX24 = 24'hFF_FFFF;

  localparam int unsigned OUT_DEPTH = 3;
  localparam int unsigned OUT_DATA_BITS = 152;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  char_value;
    logic [23:0] seq_length;
    logic [31:0] record_index;
    logic        too_long;
    logic [23:0] too_long_count;
    logic [23:0] longest_discarded;
    logic [31:0] bad_count;
  } result_t;

endpackage

@@ sv/fasta_record_stream_parser.sv @@
// FASTA record stream parser top level: byte classification, record state,
// bad-character histogram memory and a three-beat output queue. Uses frsp_pkg.
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tuser: operation, tdata: byte_value
// m_axis    out  tvalid/tready          tuser: kind, tdata: result fields
// cfg       in   cfg_we_i               cfg_idx_i, cfg_data_i
//
// One beat in per cycle while s_axis_tready is high.
// Stage one updates record state, stage two reads, increments and writes back
// the histogram entry (last write forwarded), then results queue three deep.
// Input stalls only when the output queue plus the in-flight result fill it.
// Reset clears the histogram through per-entry valid bits; no clearing pass.
module fasta_record_stream_parser #(
  parameter int unsigned LENGTH_BITS = 24,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]   s_axis_tuser,   // [1:0] operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] char_value, [31:8] seq_length, [63:32] record_index, [64] too_long,
  // [88:65] too_long_count, [112:89] longest_discarded, [144:113] bad_count
  output logic [frsp_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // [2:0] kind
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);

  localparam logic [COUNT_BITS-1:0]  CntMax = '1;
  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  // configuration
  logic [63:0] mask_low_q, mask_upper_q, mask_high_q, mask_top_q;
  logic        allow_gaps_q, nuc_mode_q, trunc_hdr_q;
  logic [23:0] max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_low_q   <= '0;
      mask_upper_q <= frsp_pkg::MASK_UPPER_RESET;
      mask_high_q  <= '0;
      mask_top_q   <= '0;
      allow_gaps_q <= 1'b0;
      nuc_mode_q   <= 1'b0;
      trunc_hdr_q  <= 1'b0;
      max_len_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (frsp_pkg::cfg_e'(cfg_idx_i))
        frsp_pkg::CFG_MASK_LOW:   mask_low_q   <= cfg_data_i;
        frsp_pkg::CFG_MASK_UPPER: mask_upper_q <= cfg_data_i;
        frsp_pkg::CFG_MASK_HIGH:  mask_high_q  <= cfg_data_i;
        frsp_pkg::CFG_MASK_TOP:   mask_top_q   <= cfg_data_i;
        frsp_pkg::CFG_ALLOW_GAPS: allow_gaps_q <= cfg_data_i[0];
        frsp_pkg::CFG_NUC_MODE:   nuc_mode_q   <= cfg_data_i[0];
        frsp_pkg::CFG_TRUNC_HDR:  trunc_hdr_q  <= cfg_data_i[0];
        frsp_pkg::CFG_MAX_LEN:    max_len_q    <= cfg_data_i[23:0];
      endcase
    end
  end

  // record state
  logic [7:0]             prev_q, prev_d;
  logic                   in_hdr_q, in_hdr_d;
  logic                   cut_q, cut_d;
  logic                   open_q, open_d;
  logic                   failed_q, failed_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [31:0]            rec_cnt_q, rec_cnt_d;
  logic [23:0]            disc_q, disc_d;
  logic [23:0]            longest_q, longest_d;

  // stage two
  logic                   s1_res_q, s1_res_d;
  logic                   s1_inc_q, s1_inc_d;
  logic                   s1_rd_q, s1_rd_d;
  logic [7:0]             s1_addr_q;
  frsp_pkg::result_t      s1_out_q, s1_out_d;

  // output queue
  frsp_pkg::result_t      fifo_q [frsp_pkg::OUT_DEPTH];
  logic [1:0]             wr_ptr_q, rd_ptr_q;
  logic [1:0]             cnt_q;

  logic s_accept, m_pop;
  logic [7:0] b;
  frsp_pkg::op_e op;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_pop    = m_axis_tvalid && m_axis_tready;
  assign b        = s_axis_tdata;
  assign op       = frsp_pkg::op_e'(s_axis_tuser);
  assign s_axis_tready = ({1'b0, cnt_q} + {2'b00, s1_res_q}) <= 3'(frsp_pkg::OUT_DEPTH - 1);

  // byte classes
  logic is_nl, is_white, is_gap, is_valid;
  logic [63:0] mask_sel;

  always_comb begin
    unique case (b[7:6])
      2'd0: mask_sel = mask_low_q;
      2'd1: mask_sel = mask_upper_q;
      2'd2: mask_sel = mask_high_q;
      2'd3: mask_sel = mask_top_q;
    endcase
    is_valid = mask_sel[b[5:0]];
    is_nl    = (b == frsp_pkg::CHAR_LF) || (b == frsp_pkg::CHAR_CR);
    is_white = is_nl || (b == frsp_pkg::CHAR_SPACE) || (b == frsp_pkg::CHAR_TAB) ||
               (b == frsp_pkg::CHAR_VT) || (b == frsp_pkg::CHAR_FF);
    is_gap   = (b == frsp_pkg::CHAR_DASH) || (b == frsp_pkg::CHAR_DOT);
  end

  // record-close values
  logic [31:0] len_ext;
  logic        too;
  logic [23:0] len_clamp, disc_nxt, longest_nxt;

  always_comb begin
    len_ext     = 32'(len_q);
    len_clamp   = (len_ext > 32'(frsp_pkg::MAX24)) ? frsp_pkg::MAX24 : len_ext[23:0];
    too         = (max_len_q != '0) && (len_ext > 32'(max_len_q));
    disc_nxt    = (too && disc_q != frsp_pkg::MAX24) ? disc_q + 24'd1 : disc_q;
    longest_nxt = (too && len_ext > 32'(longest_q)) ? len_clamp : longest_q;
  end

  logic do_close, do_open, do_seq;
  logic [7:0] seq_char;

  always_comb begin
    prev_d    = prev_q;
    in_hdr_d  = in_hdr_q;
    cut_d     = cut_q;
    open_d    = open_q;
    failed_d  = failed_q;
    len_d     = len_q;
    rec_cnt_d = rec_cnt_q;
    disc_d    = disc_q;
    longest_d = longest_q;
    s1_res_d  = 1'b0;
    s1_inc_d  = 1'b0;
    s1_rd_d   = 1'b0;
    s1_out_d  = '0;
    do_close  = 1'b0;
    do_open   = 1'b0;
    do_seq    = 1'b0;
    seq_char  = b;
    if (s_accept) begin
      unique case (op)
        frsp_pkg::OP_END: begin
          do_close = open_q;
          failed_d = 1'b0;
          prev_d   = frsp_pkg::CHAR_LF;
        end
        frsp_pkg::OP_READ: begin
          s1_res_d      = 1'b1;
          s1_rd_d       = 1'b1;
          s1_out_d.kind = frsp_pkg::KIND_COUNT;
        end
        frsp_pkg::OP_DATA: begin
          prev_d = b;
          priority if (!open_q) begin
            if (!failed_q) begin
              if (b != frsp_pkg::CHAR_GT) begin
                failed_d      = 1'b1;
                s1_res_d      = 1'b1;
                s1_out_d.kind = frsp_pkg::KIND_NOT_FASTA;
              end else begin
                do_open = 1'b1;
              end
            end
          end else if (!in_hdr_q && b == frsp_pkg::CHAR_GT &&
                       (prev_q == frsp_pkg::CHAR_LF || prev_q == frsp_pkg::CHAR_CR)) begin
            do_close = 1'b1;
            do_open  = 1'b1;
          end else if (in_hdr_q) begin
            priority if (is_nl) begin
              in_hdr_d      = 1'b0;
              s1_res_d      = 1'b1;
              s1_out_d.kind = frsp_pkg::KIND_HDR_END;
            end else if (trunc_hdr_q) begin
              if (!cut_q) begin
                if (is_white) begin
                  cut_d = 1'b1;
                end else begin
                  s1_res_d            = 1'b1;
                  s1_out_d.kind       = frsp_pkg::KIND_HDR_CHAR;
                  s1_out_d.char_value = b;
                end
              end
            end else begin
              s1_res_d            = 1'b1;
              s1_out_d.kind       = frsp_pkg::KIND_HDR_CHAR;
              s1_out_d.char_value = (b == frsp_pkg::CHAR_TAB) ? frsp_pkg::CHAR_SPACE : b;
            end
          end else begin
            priority if (is_gap) begin
              do_seq = allow_gaps_q;
            end else if (is_valid) begin
              do_seq = 1'b1;
            end else if (is_white) begin
              do_seq = 1'b0;
            end else begin
              s1_inc_d = 1'b1;
              do_seq   = 1'b1;
              seq_char = nuc_mode_q ? frsp_pkg::CHAR_N : frsp_pkg::CHAR_X;
            end
          end
        end
        default: ;
      endcase
    end
    if (do_seq) begin
      s1_res_d            = 1'b1;
      s1_out_d.kind       = frsp_pkg::KIND_SEQ_CHAR;
      s1_out_d.char_value = seq_char;
      len_d               = (len_q != LenMax) ? len_q + 1'b1 : len_q;
    end
    if (do_close) begin
      s1_res_d                   = 1'b1;
      s1_out_d.kind              = frsp_pkg::KIND_REC_END;
      s1_out_d.seq_length        = len_clamp;
      s1_out_d.record_index      = rec_cnt_q;
      s1_out_d.too_long          = too;
      s1_out_d.too_long_count    = disc_nxt;
      s1_out_d.longest_discarded = longest_nxt;
      disc_d    = disc_nxt;
      longest_d = longest_nxt;
      rec_cnt_d = rec_cnt_q + 32'd1;
      open_d    = 1'b0;
      in_hdr_d  = 1'b0;
      cut_d     = 1'b0;
      len_d     = '0;
    end
    if (do_open) begin
      open_d   = 1'b1;
      in_hdr_d = 1'b1;
      cut_d    = 1'b0;
      len_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= frsp_pkg::CHAR_LF;
      in_hdr_q  <= 1'b0;
      cut_q     <= 1'b0;
      open_q    <= 1'b0;
      failed_q  <= 1'b0;
      len_q     <= '0;
      rec_cnt_q <= '0;
      disc_q    <= '0;
      longest_q <= '0;
      s1_res_q  <= 1'b0;
      s1_inc_q  <= 1'b0;
      s1_rd_q   <= 1'b0;
    end else begin
      prev_q    <= prev_d;
      in_hdr_q  <= in_hdr_d;
      cut_q     <= cut_d;
      open_q    <= open_d;
      failed_q  <= failed_d;
      len_q     <= len_d;
      rec_cnt_q <= rec_cnt_d;
      disc_q    <= disc_d;
      longest_q <= longest_d;
      s1_res_q  <= s1_res_d;
      s1_inc_q  <= s1_inc_d;
      s1_rd_q   <= s1_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_out_q <= s1_out_d;
    if (s_accept) begin
      s1_addr_q <= b;
    end
  end

  // histogram memory, read at accept, read-modify-write in stage two
  logic [COUNT_BITS-1:0] hist_mem [256];
  logic [255:0]          hist_vld_q;
  logic [COUNT_BITS-1:0] hist_rdata_q;
  logic                  hist_hv_q;
  logic                  wr_vld_q;
  logic [7:0]            wr_addr_q;
  logic [COUNT_BITS-1:0] wr_data_q;
  logic [COUNT_BITS-1:0] cur_cnt, inc_cnt;
  logic [63:0]           cur_ext;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      hist_rdata_q <= hist_mem[b];
      hist_hv_q    <= hist_vld_q[b];
    end
    if (s1_inc_q) begin
      hist_mem[s1_addr_q] <= inc_cnt;
    end
    wr_addr_q <= s1_addr_q;
    wr_data_q <= inc_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      wr_vld_q   <= 1'b0;
    end else begin
      if (s1_inc_q) begin
        hist_vld_q[s1_addr_q] <= 1'b1;
      end
      wr_vld_q <= s1_inc_q;
    end
  end

  always_comb begin
    priority if (wr_vld_q && wr_addr_q == s1_addr_q) begin
      cur_cnt = wr_data_q;
    end else if (hist_hv_q) begin
      cur_cnt = hist_rdata_q;
    end else begin
      cur_cnt = '0;
    end
    inc_cnt = (cur_cnt != CntMax) ? cur_cnt + 1'b1 : cur_cnt;
    cur_ext = 64'(cur_cnt);
  end

  // output queue
  frsp_pkg::result_t push_val;

  always_comb begin
    push_val = s1_out_q;
    if (s1_rd_q) begin
      push_val.bad_count = (cur_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : cur_ext[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_res_q) begin
      fifo_q[wr_ptr_q] <= push_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (s1_res_q) begin
        wr_ptr_q <= (wr_ptr_q == 2'(frsp_pkg::OUT_DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
      end
      if (m_pop) begin
        rd_ptr_q <= (rd_ptr_q == 2'(frsp_pkg::OUT_DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, s1_res_q} - {1'b0, m_pop};
    end
  end

  frsp_pkg::result_t head;

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tuser  = head.kind;
  assign m_axis_tdata  = {7'd0, head.bad_count, head.longest_discarded, head.too_long_count,
                          head.too_long, head.record_index, head.seq_length, head.char_value};

  // checks
  a_queue_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} + {2'b00, s1_res_q}) <= 3'(frsp_pkg::OUT_DEPTH))
    else $error("output queue overrun");

  a_read_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_rd_q |-> s1_res_q && s1_out_q.kind == frsp_pkg::KIND_COUNT && !s1_inc_q)
    else $error("count read without its result");

  a_failed_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && op == frsp_pkg::OP_DATA && !open_q && failed_q |=> !s1_res_q && !s1_inc_q)
    else $error("failed stream produced a result");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for fasta_record_stream_parser: drives FASTA byte streams,
// predicts every result beat in a scoreboard class and compares them field by field.
// Depends on frsp_pkg and the parser RTL.
module testbench;
  import frsp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 345;

  class fasta_record_scoreboard;
    logic [63:0] mask [4];
    bit gaps_on, nuc_on, trunc_on;
    logic [23:0] len_limit;
    logic [7:0] last_byte;
    bit hdr_active, hdr_cut, rec_open, stream_bad;
    logic [23:0] seq_len, drop_count, drop_longest;
    logic [31:0] rec_num;
    logic [31:0] bad_hist [256];
    result_t parsed_items [$];
    int errors;

    function new();
      mask[0] = '0;
      mask[1] = MASK_UPPER_RESET;
      mask[2] = '0;
      mask[3] = '0;
      gaps_on = 0;
      nuc_on = 0;
      trunc_on = 0;
      len_limit = '0;
      last_byte = CHAR_LF;
      hdr_active = 0;
      hdr_cut = 0;
      rec_open = 0;
      stream_bad = 0;
      seq_len = '0;
      drop_count = '0;
      drop_longest = '0;
      rec_num = '0;
      foreach (bad_hist[i]) bad_hist[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_e idx, logic [63:0] v);
      case (idx)
        CFG_MASK_LOW:   mask[0] = v;
        CFG_MASK_UPPER: mask[1] = v;
        CFG_MASK_HIGH:  mask[2] = v;
        CFG_MASK_TOP:   mask[3] = v;
        CFG_ALLOW_GAPS: gaps_on = v[0];
        CFG_NUC_MODE:   nuc_on = v[0];
        CFG_TRUNC_HDR:  trunc_on = v[0];
        CFG_MAX_LEN:    len_limit = v[23:0];
        default: ;
      endcase
    endfunction

    function bit is_white(logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT ||
             c == CHAR_FF || c == CHAR_CR;
    endfunction

    function result_t close_record();
      result_t r;
      bit too;
      too = len_limit != 0 && seq_len > len_limit;
      if (too) begin
        if (drop_count != MAX24) drop_count++;
        if (seq_len > drop_longest) drop_longest = seq_len;
      end
      r = '0;
      r.kind = KIND_REC_END;
      r.seq_length = seq_len;
      r.record_index = rec_num;
      r.too_long = too;
      r.too_long_count = drop_count;
      r.longest_discarded = drop_longest;
      rec_num++;
      rec_open = 0;
      hdr_active = 0;
      hdr_cut = 0;
      seq_len = '0;
      return r;
    endfunction

    function result_t seq_char(logic [7:0] c);
      result_t r;
      r = '0;
      r.kind = KIND_SEQ_CHAR;
      r.char_value = c;
      if (seq_len != MAX24) seq_len++;
      return r;
    endfunction

    function void accept_input(logic [1:0] op, logic [7:0] b);
      result_t r;
      logic [7:0] prev;
      bit has;
      r = '0;
      has = 0;
      case (op)
        OP_END: begin
          if (rec_open) begin
            r = close_record();
            has = 1;
          end
          stream_bad = 0;
          last_byte = CHAR_LF;
        end
        OP_READ: begin
          r.kind = KIND_COUNT;
          r.bad_count = bad_hist[b];
          has = 1;
        end
        OP_DATA: begin
          prev = last_byte;
          last_byte = b;
          if (!rec_open) begin
            if (!stream_bad) begin
              if (b != CHAR_GT) begin
                stream_bad = 1;
                r.kind = KIND_NOT_FASTA;
                has = 1;
              end else begin
                rec_open = 1;
                hdr_active = 1;
                hdr_cut = 0;
                seq_len = '0;
              end
            end
          end else if (!hdr_active && b == CHAR_GT && (prev == CHAR_LF || prev == CHAR_CR)) begin
            r = close_record();
            has = 1;
            rec_open = 1;
            hdr_active = 1;
            hdr_cut = 0;
          end else if (hdr_active) begin
            if (b == CHAR_LF || b == CHAR_CR) begin
              hdr_active = 0;
              r.kind = KIND_HDR_END;
              has = 1;
            end else if (trunc_on) begin
              if (!hdr_cut) begin
                if (is_white(b)) begin
                  hdr_cut = 1;
                end else begin
                  r.kind = KIND_HDR_CHAR;
                  r.char_value = b;
                  has = 1;
                end
              end
            end else begin
              r.kind = KIND_HDR_CHAR;
              r.char_value = (b == CHAR_TAB) ? CHAR_SPACE : b;
              has = 1;
            end
          end else if (b == CHAR_DASH || b == CHAR_DOT) begin
            if (gaps_on) begin
              r = seq_char(b);
              has = 1;
            end
          end else if (mask[b[7:6]][b[5:0]]) begin
            r = seq_char(b);
            has = 1;
          end else if (!is_white(b)) begin
            if (bad_hist[b] != '1) bad_hist[b]++;
            r = seq_char(nuc_on ? CHAR_N : CHAR_X);
            has = 1;
          end
        end
        default: ;
      endcase
      if (has) parsed_items.push_back(r);
    endfunction

    function void compare(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_output(logic [2:0] kind, logic [OUT_DATA_BITS-1:0] d);
      result_t e;
      if (parsed_items.size() == 0) begin
        $error("result beat with nothing pending: kind %0d", kind);
        errors++;
        return;
      end
      e = parsed_items.pop_front();
      compare("kind", e.kind, kind);
      compare("char_value", e.char_value, d[7:0]);
      compare("seq_length", e.seq_length, d[31:8]);
      compare("record_index", e.record_index, d[63:32]);
      compare("too_long", e.too_long, d[64]);
      compare("too_long_count", e.too_long_count, d[88:65]);
      compare("longest_discarded", e.longest_discarded, d[112:89]);
      compare("bad_count", e.bad_count, d[144:113]);
      compare("padding", '0, d[OUT_DATA_BITS-1:145]);
    endfunction

    function int pending();
      return parsed_items.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  fasta_record_scoreboard records = new();
  int unsigned tx_idle_pct = 26;
  int unsigned rx_idle_pct = 45;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;
  bit hold_rx = 0;

  fasta_record_stream_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random backpressure, or one long hold-off on request
  initial begin
    forever begin
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      records.check_output(m_axis_tuser, m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    records.accept_input(op, b);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (records.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [63:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    records.write_reg(idx, v);
  endtask

  task automatic apply_config(input logic [63:0] m0, m1, m2, m3,
                              input bit gaps, nuc, trunc, input logic [23:0] limit);
    write_reg(CFG_MASK_LOW, m0);
    write_reg(CFG_MASK_UPPER, m1);
    write_reg(CFG_MASK_HIGH, m2);
    write_reg(CFG_MASK_TOP, m3);
    write_reg(CFG_ALLOW_GAPS, 64'(gaps));
    write_reg(CFG_NUC_MODE, 64'(nuc));
    write_reg(CFG_TRUNC_HDR, 64'(trunc));
    write_reg(CFG_MAX_LEN, 64'(limit));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] header_byte();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70) return 8'($urandom_range(126, 33));
    if (k < 80) return CHAR_SPACE;
    if (k < 90) return CHAR_TAB;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] residue_byte();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 45) return $urandom_range(1) ? 8'("A" + $urandom_range(25))
                                         : 8'("a" + $urandom_range(25));
    if (k < 55) return $urandom_range(1) ? CHAR_DASH : CHAR_DOT;
    if (k < 65) begin
      case ($urandom_range(3))
        0: return CHAR_SPACE;
        1: return CHAR_TAB;
        2: return CHAR_VT;
        default: return CHAR_FF;
      endcase
    end
    if (k < 70) return CHAR_GT;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_line_end();
    case ($urandom_range(2))
      0: send_beat(OP_DATA, CHAR_LF);
      1: send_beat(OP_DATA, CHAR_CR);
      default: begin
        send_beat(OP_DATA, CHAR_CR);
        send_beat(OP_DATA, CHAR_LF);
      end
    endcase
  endtask

  task automatic send_record();
    int unsigned lines;
    send_beat(OP_DATA, CHAR_GT);
    repeat ($urandom_range(10)) send_beat(OP_DATA, header_byte());
    send_line_end();
    lines = $urandom_range(3);
    repeat (lines) begin
      repeat ($urandom_range(15)) send_beat(OP_DATA, residue_byte());
      send_line_end();
    end
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned k;
    target = items_sent + target;
    while (items_sent < target) begin
      k = $urandom_range(99);
      if (k < 75) begin
        send_record();
      end else if (k < 83) begin
        send_beat(OP_READ, 8'($urandom_range(255)));
      end else if (k < 88) begin
        send_beat(OP_END, 8'($urandom_range(255)));
      end else if (k < 92) begin
        send_beat(OP_UNUSED, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(5, 1))
          send_beat($urandom_range(3) == 0 ? 2'($urandom_range(3)) : OP_DATA,
                    8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_config('0, MASK_UPPER_RESET, '0, '0, 0, 0, 0, 24'd4);
    // stream start without '>', then ignored byte until end of input
    send_beat(OP_DATA, "A");
    send_beat(OP_DATA, "B");
    send_beat(OP_END, 8'h00);
    send_beat(OP_DATA, CHAR_GT);
    send_beat(OP_DATA, "h");
    send_beat(OP_DATA, CHAR_TAB);
    send_beat(OP_DATA, 8'hFF);
    send_beat(OP_DATA, 8'h00);
    send_beat(OP_DATA, CHAR_CR);
    send_beat(OP_DATA, CHAR_LF);
    send_beat(OP_DATA, "A");
    send_beat(OP_DATA, "c");
    send_beat(OP_DATA, CHAR_DASH);
    send_beat(OP_DATA, CHAR_GT);
    send_beat(OP_DATA, 8'h00);
    send_beat(OP_DATA, 8'hFF);
    send_beat(OP_DATA, CHAR_SPACE);
    send_beat(OP_DATA, CHAR_LF);
    send_beat(OP_DATA, CHAR_GT);
    send_beat(OP_DATA, CHAR_LF);
    send_beat(OP_READ, CHAR_GT);
    send_beat(OP_READ, 8'hFF);
    send_beat(OP_UNUSED, 8'hFF);
    send_beat(OP_END, 8'hFF);
    wait_idle();

    apply_config('1, {$urandom, $urandom}, '1, '0, 1, 1, 1, MAX24);
    run_random(PHASE_ITEMS);
    wait_idle();

    tx_idle_pct = 45;
    rx_idle_pct = 26;
    apply_config('0, MASK_UPPER_RESET, {$urandom, $urandom}, '1, 0, 0, 0, 24'd8);
    run_random(PHASE_ITEMS);
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, $urandom_range(1), $urandom_range(1),
                 $urandom_range(1), 24'($urandom_range(30, 1)));
    hold_rx = 1;
    run_random(PHASE_ITEMS);
    wait_idle();

    if (records.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
